// File: hdl/compass_heading_autocal_macros.svh
// Assertion macros shared by the compass heading block.
`ifndef COMPASS_HEADING_AUTOCAL_MACROS_SVH
`define COMPASS_HEADING_AUTOCAL_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define CHA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("compass heading check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define CHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("compass heading check failed");

`endif

// File: hdl/cha_pkg.sv
// Shared types, constants and the arctangent table for the compass heading block.
package cha_pkg;

  localparam int FIELD_BITS_DEF    = 16;
  localparam int AVG_FRAC_BITS_DEF = 8;
  localparam int CORDIC_STEPS_DEF  = 14;

  localparam int ANG_PI     = 25736;
  localparam int ANG_TWO_PI = 51472;

  // register indexes
  localparam logic [2:0] REG_SPIKE_LIMIT = 3'd0;
  localparam logic [2:0] REG_WEIGHT      = 3'd1;
  localparam logic [2:0] REG_SPAN_FLOOR  = 3'd2;
  localparam logic [2:0] REG_LOCK_THR    = 3'd3;
  localparam logic [2:0] REG_MOUNT       = 3'd4;

  localparam logic [15:0] SPIKE_LIMIT_RST = 16'd150;
  localparam logic [8:0]  WEIGHT_RST      = 9'd77;
  localparam logic [14:0] SPAN_FLOOR_RST  = 15'd100;
  localparam logic [30:0] LOCK_THR_RST    = 31'd16777216;
  localparam logic [15:0] MOUNT_RST       = 16'd0;

  // result status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_SPIKE        = 2'd1;
  localparam logic [1:0] ST_NOT_CAL      = 2'd2;
  localparam logic [1:0] ST_SIGN_UNKNOWN = 2'd3;

  // compass sign
  localparam logic [1:0] LOCK_NONE = 2'd0;
  localparam logic [1:0] LOCK_POS  = 2'd1;
  localparam logic [1:0] LOCK_NEG  = 2'd2;

  typedef struct packed {
    logic load_in;
    logic diff;
    logic upd_y;
    logic upd_z;
    logic trunc;
    logic span;
    logic mul_x;
    logic mul_y;
    logic pre;
    logic iter;
    logic wrap;
    logic cmul;
    logic cacc;
    logic set_spike;
    logic set_nocal;
    logic fin;
  } cha_cmd_t;

  typedef struct packed {
    logic spike;
    logic short_span;
  } cha_stat_t;

  // atan(2^-i) in Q2.13, rounded
  function automatic logic [12:0] atan_lut(input logic [4:0] idx);
    logic [12:0] v;
    case (idx)
      5'd0:    v = 13'd6434;
      5'd1:    v = 13'd3798;
      5'd2:    v = 13'd2007;
      5'd3:    v = 13'd1019;
      5'd4:    v = 13'd511;
      5'd5:    v = 13'd256;
      5'd6:    v = 13'd128;
      5'd7:    v = 13'd64;
      5'd8:    v = 13'd32;
      5'd9:    v = 13'd16;
      5'd10:   v = 13'd8;
      5'd11:   v = 13'd4;
      5'd12:   v = 13'd2;
      5'd13:   v = 13'd1;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/cha_ctrl.sv
// Sequencer for the compass heading datapath.
module cha_ctrl #(
  parameter int CORDIC_STEPS = cha_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            out_free,
  input  cha_pkg::cha_stat_t              stat,
  output cha_pkg::cha_cmd_t               cmd,
  output logic [$clog2(CORDIC_STEPS)-1:0] step
);
  import cha_pkg::*;

  localparam int SW = $clog2(CORDIC_STEPS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_SPIKE = 4'd2;
  localparam logic [3:0] S_UPY   = 4'd3;
  localparam logic [3:0] S_UPZ   = 4'd4;
  localparam logic [3:0] S_TRUNC = 4'd5;
  localparam logic [3:0] S_SPAN  = 4'd6;
  localparam logic [3:0] S_FLOOR = 4'd7;
  localparam logic [3:0] S_MULX  = 4'd8;
  localparam logic [3:0] S_MULY  = 4'd9;
  localparam logic [3:0] S_PRE   = 4'd10;
  localparam logic [3:0] S_ITER  = 4'd11;
  localparam logic [3:0] S_WRAP  = 4'd12;
  localparam logic [3:0] S_CMUL  = 4'd13;
  localparam logic [3:0] S_CACC  = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  logic [3:0]    state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign step     = step_r;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_SPIKE;
      end
      S_SPIKE: begin
        if (stat.spike) begin
          cmd.set_spike = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          state_nxt = S_UPY;
        end
      end
      S_UPY: begin
        cmd.upd_y = 1'b1;
        state_nxt = S_UPZ;
      end
      S_UPZ: begin
        cmd.upd_z = 1'b1;
        state_nxt = S_TRUNC;
      end
      S_TRUNC: begin
        cmd.trunc = 1'b1;
        state_nxt = S_SPAN;
      end
      S_SPAN: begin
        cmd.span  = 1'b1;
        state_nxt = S_FLOOR;
      end
      S_FLOOR: begin
        if (stat.short_span) begin
          cmd.set_nocal = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          state_nxt = S_MULX;
        end
      end
      S_MULX: begin
        cmd.mul_x = 1'b1;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y = 1'b1;
        state_nxt = S_PRE;
      end
      S_PRE: begin
        cmd.pre   = 1'b1;
        step_nxt  = '0;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (step_r == SW'(CORDIC_STEPS - 1)) begin
          state_nxt = S_WRAP;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = S_CMUL;
      end
      S_CMUL: begin
        cmd.cmul  = 1'b1;
        state_nxt = S_CACC;
      end
      S_CACC: begin
        cmd.cacc  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: hdl/cha_dp.sv
// Datapath: averaging, spike test, span tracking, CORDIC and sign learning.
module cha_dp #(
  parameter int FIELD_BITS    = cha_pkg::FIELD_BITS_DEF,
  parameter int AVG_FRAC_BITS = cha_pkg::AVG_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS  = cha_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cha_pkg::cha_cmd_t               cmd,
  input  logic [$clog2(CORDIC_STEPS)-1:0] step,
  output cha_pkg::cha_stat_t              stat,
  input  logic signed [FIELD_BITS-1:0]    field_y,
  input  logic signed [FIELD_BITS-1:0]    field_z,
  input  logic signed [15:0]              yaw_rate,
  input  logic [15:0]                     spike_limit,
  input  logic [8:0]                      smoothing_weight,
  input  logic [14:0]                     span_floor,
  input  logic [30:0]                     sign_lock_threshold,
  input  logic signed [15:0]              mount_offset,
  output logic                            res_heading_valid,
  output logic signed [15:0]              res_heading,
  output logic [1:0]                      res_status
);
  import cha_pkg::*;

  localparam int F  = FIELD_BITS;
  localparam int A  = AVG_FRAC_BITS;
  localparam int AW = F + A;
  localparam int DW = ((F > 16) ? F : 16) + A + 2;
  localparam int PW = DW + 10;
  localparam int CW = F + 2;
  localparam int XW = 2 * F + 4;
  localparam int ZW = 18;
  localparam int FW = ((F > 15) ? F : 15) + 1;

  logic signed [F-1:0]  fy_r, fz_r;
  logic signed [15:0]   rate_r;
  logic signed [AW-1:0] avg_y_r, avg_z_r;
  logic                 seeded_r;
  logic signed [DW-1:0] dy_r, dz_r;
  logic signed [F-1:0]  lo_y_r, hi_y_r, lo_z_r, hi_z_r;
  logic signed [F-1:0]  iy_r, iz_r, sy_r, sz_r;
  logic signed [CW-1:0] cy_r, cz_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic signed [15:0]   raw_r, last_r;
  logic                 have_last_r;
  logic signed [31:0]   prod_r, corr_r;
  logic [1:0]           lock_r, code_r;

  logic signed [AW-1:0] fy_s, fz_s;
  logic signed [DW-1:0] lim_w;
  logic [8:0]           wgt;
  logic signed [DW-1:0] mul_d;
  logic signed [PW-1:0] wprod, wshift;
  logic signed [F-1:0]  iy_c, iz_c;
  logic signed [F:0]    dspan_y, dspan_z;
  logic signed [F:0]    span_max;
  logic signed [CW-1:0] mul_a;
  logic signed [F-1:0]  mul_b;
  logic signed [XW-1:0] xy_prod, xs, ys;
  logic signed [ZW-1:0] atan_v;
  logic signed [16:0]   dang;
  logic signed [15:0]   dang_w;
  logic signed [33:0]   csum, thr_w;
  logic signed [31:0]   csat;
  logic [1:0]           lock_nxt;
  logic signed [16:0]   sraw;
  logic signed [17:0]   hsum;
  logic signed [15:0]   hwrap;

  function automatic logic signed [F-1:0] trunc_int(input logic signed [AW-1:0] v);
    logic signed [F-1:0] fl;
    fl = v[AW-1:A];
    return fl + F'({1'b0, v[AW-1] & (|v[A-1:0])});
  endfunction

  assign fy_s  = $signed({fy_r, {A{1'b0}}});
  assign fz_s  = $signed({fz_r, {A{1'b0}}});
  assign lim_w = $signed(DW'({spike_limit, {A{1'b0}}}));

  assign stat.spike = (dy_r > lim_w) || (dy_r < -lim_w) ||
                      (dz_r > lim_w) || (dz_r < -lim_w);
  assign stat.short_span = (FW'(sy_r) < FW'($signed({1'b0, span_floor}))) ||
                           (FW'(sz_r) < FW'($signed({1'b0, span_floor})));

  // shared weight multiplier
  assign wgt    = (smoothing_weight > 9'd256) ? 9'd256 : smoothing_weight;
  assign mul_d  = cmd.upd_z ? dz_r : dy_r;
  assign wprod  = PW'($signed({1'b0, wgt})) * PW'(mul_d);
  assign wshift = wprod >>> 8;

  assign iy_c = trunc_int(avg_y_r);
  assign iz_c = trunc_int(avg_z_r);

  assign span_max = $signed({2'b00, {(F-1){1'b1}}});
  assign dspan_y  = (F+1)'(hi_y_r) - (F+1)'(lo_y_r);
  assign dspan_z  = (F+1)'(hi_z_r) - (F+1)'(lo_z_r);

  // shared scaling multiplier: x = cy*sz, y = cz*sy
  assign mul_a   = cmd.mul_y ? cz_r : cy_r;
  assign mul_b   = cmd.mul_y ? sy_r : sz_r;
  assign xy_prod = XW'(mul_a) * XW'(mul_b);

  assign xs     = x_r >>> step;
  assign ys     = y_r >>> step;
  assign atan_v = ZW'($signed({1'b0, atan_lut(5'(step))}));

  // angle change, wrapped
  assign dang = 17'(raw_r) - 17'(last_r);
  always_comb begin
    if (dang > 17'(ANG_PI))       dang_w = 16'(dang - 17'(ANG_TWO_PI));
    else if (dang < -17'(ANG_PI)) dang_w = 16'(dang + 17'(ANG_TWO_PI));
    else                          dang_w = dang[15:0];
  end

  // lock decision uses the saturated sum
  assign csum  = 34'(corr_r) + 34'(prod_r);
  assign thr_w = $signed({3'b000, sign_lock_threshold});
  always_comb begin
    if (csum > 34'sh0_7FFF_FFFF)       csat = 32'sh7FFF_FFFF;
    else if (csum < -34'sh0_8000_0000) csat = -32'sh8000_0000;
    else                               csat = csum[31:0];
    lock_nxt = lock_r;
    if (have_last_r && lock_r == LOCK_NONE) begin
      if (34'(csat) > thr_w)       lock_nxt = LOCK_POS;
      else if (34'(csat) < -thr_w) lock_nxt = LOCK_NEG;
    end
  end

  // final heading
  assign sraw = (lock_r == LOCK_POS) ? 17'(raw_r) : -17'(raw_r);
  assign hsum = 18'(sraw) + 18'(mount_offset);
  always_comb begin
    if (hsum > 18'(ANG_PI))       hwrap = 16'(hsum - 18'(ANG_TWO_PI));
    else if (hsum < -18'(ANG_PI)) hwrap = 16'(hsum + 18'(ANG_TWO_PI));
    else                          hwrap = hsum[15:0];
  end

  assign res_heading_valid = (code_r == ST_OK);
  assign res_heading       = (code_r == ST_OK) ? hwrap : 16'sd0;
  assign res_status        = code_r;

  // item payload and per-item scratch
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      fy_r   <= field_y;
      fz_r   <= field_z;
      rate_r <= yaw_rate;
    end
    if (cmd.diff) begin
      if (seeded_r) begin
        dy_r <= DW'(fy_s) - DW'(avg_y_r);
        dz_r <= DW'(fz_s) - DW'(avg_z_r);
      end else begin
        dy_r <= '0;
        dz_r <= '0;
      end
    end
    if (cmd.trunc) begin
      iy_r <= iy_c;
      iz_r <= iz_c;
    end
    if (cmd.span) begin
      sy_r <= (dspan_y > span_max) ? span_max[F-1:0] : dspan_y[F-1:0];
      sz_r <= (dspan_z > span_max) ? span_max[F-1:0] : dspan_z[F-1:0];
      cy_r <= (CW'(iy_r) <<< 1) - CW'(lo_y_r) - CW'(hi_y_r);
      cz_r <= (CW'(iz_r) <<< 1) - CW'(lo_z_r) - CW'(hi_z_r);
    end
    if (cmd.mul_x) x_r <= xy_prod;
    if (cmd.mul_y) y_r <= xy_prod;
    if (cmd.pre) begin
      if (x_r < 0) begin
        z_r <= (y_r >= 0) ? ZW'(ANG_PI) : -ZW'(ANG_PI);
        x_r <= -x_r;
        y_r <= -y_r;
      end else begin
        z_r <= '0;
      end
    end
    if (cmd.iter) begin
      if (y_r >= 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_v;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_v;
      end
    end
    if (cmd.wrap) begin
      if (z_r > ZW'(ANG_PI))       raw_r <= 16'(z_r - ZW'(ANG_TWO_PI));
      else if (z_r < -ZW'(ANG_PI)) raw_r <= 16'(z_r + ZW'(ANG_TWO_PI));
      else                         raw_r <= z_r[15:0];
    end
    if (cmd.cmul) prod_r <= 32'(rate_r) * 32'(dang_w);
  end

  // calibration and sign-learning state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_y_r     <= '0;
      avg_z_r     <= '0;
      seeded_r    <= 1'b0;
      lo_y_r      <= $signed({1'b0, {(F-1){1'b1}}});
      lo_z_r      <= $signed({1'b0, {(F-1){1'b1}}});
      hi_y_r      <= $signed({1'b1, {(F-1){1'b0}}});
      hi_z_r      <= $signed({1'b1, {(F-1){1'b0}}});
      last_r      <= '0;
      have_last_r <= 1'b0;
      corr_r      <= '0;
      lock_r      <= LOCK_NONE;
      code_r      <= ST_OK;
    end else begin
      if (cmd.diff && !seeded_r) begin
        avg_y_r  <= fy_s;
        avg_z_r  <= fz_s;
        seeded_r <= 1'b1;
      end
      if (cmd.upd_y) avg_y_r <= avg_y_r + AW'(wshift);
      if (cmd.upd_z) avg_z_r <= avg_z_r + AW'(wshift);
      if (cmd.trunc) begin
        if (iy_c < lo_y_r) lo_y_r <= iy_c;
        if (iy_c > hi_y_r) hi_y_r <= iy_c;
        if (iz_c < lo_z_r) lo_z_r <= iz_c;
        if (iz_c > hi_z_r) hi_z_r <= iz_c;
      end
      if (cmd.set_spike) code_r <= ST_SPIKE;
      if (cmd.set_nocal) code_r <= ST_NOT_CAL;
      if (cmd.cacc) begin
        if (have_last_r && lock_r == LOCK_NONE) corr_r <= csat;
        lock_r      <= lock_nxt;
        last_r      <= raw_r;
        have_last_r <= 1'b1;
        code_r      <= (lock_nxt == LOCK_NONE) ? ST_SIGN_UNKNOWN : ST_OK;
      end
    end
  end

endmodule

// File: hdl/compass_heading_autocal.sv
// Top level of the self-calibrating compass heading block.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | field_y, field_z, yaw_rate
//   out_    | output    | out_valid / out_ready | heading_valid, heading, status
//   cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// One request at a time: a spike is dropped after the spike test, an
// uncalibrated sample after the span floor check, and a full heading
// runs the serial CORDIC, one micro-rotation per cycle.
// Reset is synchronous, active low, and clears calibration and sign state.
// The result sits in an output register, so a new request is taken while
// the previous result waits; a stalled output holds the sequencer at its
// last step only when a second result is ready.
module compass_heading_autocal #(
  parameter int FIELD_BITS    = cha_pkg::FIELD_BITS_DEF,
  parameter int AVG_FRAC_BITS = cha_pkg::AVG_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS  = cha_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [FIELD_BITS-1:0] in_field_y,
  input  logic signed [FIELD_BITS-1:0] in_field_z,
  input  logic signed [15:0]           in_yaw_rate,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_heading_valid,
  output logic signed [15:0]           out_heading,
  output logic [1:0]                   out_status,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [30:0]                  cfg_wdata
);
  import cha_pkg::*;

  // configuration registers
  logic [15:0]        spike_limit_r;
  logic [8:0]         weight_r;
  logic [14:0]        span_floor_r;
  logic [30:0]        lock_thr_r;
  logic signed [15:0] mount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spike_limit_r <= SPIKE_LIMIT_RST;
      weight_r      <= WEIGHT_RST;
      span_floor_r  <= SPAN_FLOOR_RST;
      lock_thr_r    <= LOCK_THR_RST;
      mount_r       <= MOUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPIKE_LIMIT: spike_limit_r <= cfg_wdata[15:0];
        REG_WEIGHT:      weight_r      <= cfg_wdata[8:0];
        REG_SPAN_FLOOR:  span_floor_r  <= cfg_wdata[14:0];
        REG_LOCK_THR:    lock_thr_r    <= cfg_wdata;
        REG_MOUNT:       mount_r       <= $signed(cfg_wdata[15:0]);
        default: ;
      endcase
    end
  end

  cha_cmd_t                        cmd;
  cha_stat_t                       stat;
  logic [$clog2(CORDIC_STEPS)-1:0] step;
  logic                            out_free;
  logic                            res_hv;
  logic signed [15:0]              res_hdg;
  logic [1:0]                      res_st;

  // output register
  logic               out_valid_r;
  logic               out_hv_r;
  logic signed [15:0] out_hdg_r;
  logic [1:0]         out_st_r;

  assign out_free = !out_valid_r || out_ready;

  cha_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .step     (step)
  );

  cha_dp #(
    .FIELD_BITS   (FIELD_BITS),
    .AVG_FRAC_BITS(AVG_FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .step               (step),
    .stat               (stat),
    .field_y            (in_field_y),
    .field_z            (in_field_z),
    .yaw_rate           (in_yaw_rate),
    .spike_limit        (spike_limit_r),
    .smoothing_weight   (weight_r),
    .span_floor         (span_floor_r),
    .sign_lock_threshold(lock_thr_r),
    .mount_offset       (mount_r),
    .res_heading_valid  (res_hv),
    .res_heading        (res_hdg),
    .res_status         (res_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_hv_r  <= res_hv;
      out_hdg_r <= res_hdg;
      out_st_r  <= res_st;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_heading_valid = out_hv_r;
  assign out_heading       = out_hdg_r;
  assign out_status        = out_st_r;

`include "compass_heading_autocal_macros.svh"

  // a usable heading always carries the ok status
  `CHA_ASSERT_NOW(a_valid_ok, out_valid && out_heading_valid, out_status == ST_OK)
  // results without an angle report a zero heading
  `CHA_ASSERT_NOW(a_zero_hdg, out_valid && !out_heading_valid, out_heading == 16'sd0)
  // the sequencer is busy right after taking a request
  `CHA_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)

endmodule
